FILE: src/rfsa_pkg.sv
// Shared sizes, codes and the cell control word for the free slot allocator.
package rfsa_pkg;

    // Grid shape.
    localparam int ROWS     = 5;
    localparam int COLS     = 6;
    localparam int TOTAL    = ROWS * COLS;

    // Derived widths.
    localparam int IDX_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CNT_W    = $clog2(TOTAL + 1);
    localparam int SER_W    = CNT_W;
    localparam int ROW_W    = $clog2(ROWS + 1);
    localparam int COL_W    = $clog2(COLS + 1);
    localparam int CHOICE_W = 16;
    localparam int STEP_W   = $clog2(CHOICE_W);

    // Port field widths.
    localparam int STATUS_W = 2;
    localparam int OSER_W   = 5;
    localparam int OROW_W   = 3;
    localparam int OCOL_W   = 3;
    localparam int OFREE_W  = 5;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [SER_W-1:0] serial_t;

    // Mode codes.
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic    alloc;
        logic    release_en;
        idx_t    pick;
        count_t  fcount;
        serial_t serial;
    } cell_ctl_t;

endpackage

FILE: src/rfsa_cell.sv
// One cell of the chain: a free list entry and the occupancy bit of one slot.
module rfsa_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rfsa_pkg::idx_t     idx,
    input  rfsa_pkg::cell_ctl_t ctl,
    input  rfsa_pkg::serial_t  entry_up,
    output rfsa_pkg::serial_t  entry,
    output logic               occ
);
    import rfsa_pkg::*;

    serial_t entry_reg;
    serial_t entry_next;
    logic    occ_reg;
    logic    occ_next;
    logic    slot_hit;

    // This cell's slot is the one being allocated or released.
    assign slot_hit = ((SER_W'(idx) + SER_W'(1)) == ctl.serial);

    // Shift down above the picked entry, take the appended serial, update the map.
    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (ctl.alloc && (idx >= ctl.pick))
        begin
            entry_next = entry_up;
        end
        if (ctl.release_en && (CNT_W'(idx) == ctl.fcount))
        begin
            entry_next = ctl.serial;
        end
        if (slot_hit && ctl.alloc)
        begin
            occ_next = 1'b1;
        end
        if (slot_hit && ctl.release_en)
        begin
            occ_next = 1'b0;
        end
    end

    // Entry resets to its own serial; the slot starts free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= SER_W'(idx) + SER_W'(1);
            occ_reg   <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            occ_reg   <= occ_next;
        end
    end

    assign entry = entry_reg;
    assign occ   = occ_reg;

endmodule

FILE: src/rfsa_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module rfsa_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rfsa_pkg::CHOICE_W-1:0] dividend,
    input  rfsa_pkg::count_t              divisor,
    output logic                          done,
    output rfsa_pkg::count_t              remainder
);
    import rfsa_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [CHOICE_W-1:0] quo_reg;
    logic [CHOICE_W-1:0] quo_next;
    count_t              rem_reg;
    count_t              rem_next;
    count_t              div_reg;
    count_t              div_next;
    logic [CNT_W:0]      trial;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[CHOICE_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(CHOICE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/random_free_slot_allocator.sv
// Free slot allocator over a ROWS by COLS grid, one word at a time. An accepted
// word goes through the bit-serial remainder unit over its CHOICE_W (16) bits,
// then a free list update for an allocate or an occupancy scan for a release (the
// occupancy scan walks the cell chain one slot per cycle), then the split of the
// serial into row and column, and last the load of the output register, which
// waits while an untaken result still sits there; rejected words go straight to
// that load. A new word is accepted as soon as the previous result sits in the
// output register, even if it is not yet taken.
module random_free_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [rfsa_pkg::CHOICE_W-1:0] choice,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rfsa_pkg::STATUS_W-1:0] status,
    output logic [rfsa_pkg::OSER_W-1:0]   slot_serial,
    output logic [rfsa_pkg::OROW_W-1:0]   slot_row,
    output logic [rfsa_pkg::OCOL_W-1:0]   slot_column,
    output logic [rfsa_pkg::OFREE_W-1:0]  free_total
);
    import rfsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ALLOC,
        S_SCAN,
        S_ROWCOL,
        S_FIN
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  mode_reg;
    logic                  mode_next;
    count_t                fcount_reg;
    count_t                fcount_next;
    count_t                pick_reg;
    count_t                pick_next;
    idx_t                  scan_reg;
    idx_t                  scan_next;
    serial_t               serial_reg;
    serial_t               serial_next;
    serial_t               rc_rem_reg;
    serial_t               rc_rem_next;
    logic [ROW_W-1:0]      row_reg;
    logic [ROW_W-1:0]      row_next;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [STATUS_W-1:0]   res_status_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [OSER_W-1:0]     oser_reg;
    logic [OSER_W-1:0]     oser_next;
    logic [OROW_W-1:0]     orow_reg;
    logic [OROW_W-1:0]     orow_next;
    logic [OCOL_W-1:0]     ocol_reg;
    logic [OCOL_W-1:0]     ocol_next;
    logic [OFREE_W-1:0]    ofree_reg;
    logic [OFREE_W-1:0]    ofree_next;

    cell_ctl_t             ctl;
    serial_t               entry_w [TOTAL];
    serial_t               up_w [TOTAL];
    logic [TOTAL-1:0]      occ_vec;
    serial_t               sel_entry;
    logic                  div_start;
    count_t                div_divisor;
    logic                  div_done;
    count_t                div_rem;
    logic                  accept;

    assign accept = in_valid && in_ready;

    // Chain of cells, each handing its entry to the cell below.
    for (genvar g = 0; g < TOTAL; g++)
    begin : g_cell
        if (g < TOTAL - 1)
        begin : g_up
            assign up_w[g] = entry_w[g+1];
        end
        else
        begin : g_top
            assign up_w[g] = '0;
        end

        rfsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (IDX_W'(g)),
            .ctl      (ctl),
            .entry_up (up_w[g]),
            .entry    (entry_w[g]),
            .occ      (occ_vec[g])
        );
    end

    // Remainder unit that turns the random word into a position.
    rfsa_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (choice),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Entry at the picked free list position.
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < TOTAL; i++)
        begin
            if (pick_reg[IDX_W-1:0] == IDX_W'(i))
            begin
                sel_entry = sel_entry | entry_w[i];
            end
        end
    end

    // Sequencer: modulo, free list update or occupancy scan, row and column split.
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        fcount_next     = fcount_reg;
        pick_next       = pick_reg;
        scan_next       = scan_reg;
        serial_next     = serial_reg;
        rc_rem_next     = rc_rem_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        oser_next       = oser_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        ofree_next      = ofree_reg;
        div_start       = 1'b0;
        div_divisor     = fcount_reg;
        ctl             = '0;
        ctl.pick        = pick_reg[IDX_W-1:0];
        ctl.fcount      = fcount_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    if ((mode == MODE_ALLOC) && (fcount_reg == '0))
                    begin
                        res_status_next = ST_FULL;
                        serial_next     = '0;
                        row_next        = '0;
                        col_next        = '0;
                        state_next      = S_FIN;
                    end
                    else if ((mode == MODE_RELEASE) && (fcount_reg == CNT_W'(TOTAL)))
                    begin
                        res_status_next = ST_EMPTY;
                        serial_next     = '0;
                        row_next        = '0;
                        col_next        = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        if (mode == MODE_RELEASE)
                        begin
                            div_divisor = CNT_W'(TOTAL) - fcount_reg;
                        end
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pick_next = div_rem;
                    scan_next = '0;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_ALLOC:
            begin
                ctl.alloc       = 1'b1;
                ctl.serial      = sel_entry;
                serial_next     = sel_entry;
                rc_rem_next     = sel_entry - SER_W'(1);
                row_next        = '0;
                fcount_next     = fcount_reg - CNT_W'(1);
                res_status_next = ST_ALLOC;
                state_next      = S_ROWCOL;
            end
            S_SCAN:
            begin
                if (occ_vec[scan_reg] && (pick_reg == '0))
                begin
                    ctl.release_en  = 1'b1;
                    ctl.serial      = SER_W'(scan_reg) + SER_W'(1);
                    serial_next     = SER_W'(scan_reg) + SER_W'(1);
                    rc_rem_next     = SER_W'(scan_reg);
                    row_next        = '0;
                    fcount_next     = fcount_reg + CNT_W'(1);
                    res_status_next = ST_REL;
                    state_next      = S_ROWCOL;
                end
                else if (scan_reg == IDX_W'(TOTAL - 1))
                begin
                    // Nothing found: reported as an empty reject.
                    res_status_next = ST_EMPTY;
                    serial_next     = '0;
                    row_next        = '0;
                    col_next        = '0;
                    state_next      = S_FIN;
                end
                else
                begin
                    if (occ_vec[scan_reg])
                    begin
                        pick_next = pick_reg - CNT_W'(1);
                    end
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            S_ROWCOL:
            begin
                if (rc_rem_reg >= SER_W'(COLS))
                begin
                    rc_rem_next = rc_rem_reg - SER_W'(COLS);
                    row_next    = row_reg + ROW_W'(1);
                end
                else
                begin
                    row_next   = row_reg + ROW_W'(1);
                    col_next   = COL_W'(rc_rem_reg) + COL_W'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    oser_next      = OSER_W'(serial_reg);
                    orow_next      = OROW_W'(row_reg);
                    ocol_next      = OCOL_W'(col_reg);
                    ofree_next     = OFREE_W'(fcount_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fcount_reg    <= CNT_W'(TOTAL);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fcount_reg    <= fcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        pick_reg       <= pick_next;
        scan_reg       <= scan_next;
        serial_reg     <= serial_next;
        rc_rem_reg     <= rc_rem_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        res_status_reg <= res_status_next;
        status_reg     <= status_next;
        oser_reg       <= oser_next;
        orow_reg       <= orow_next;
        ocol_reg       <= ocol_next;
        ofree_reg      <= ofree_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_serial = oser_reg;
    assign slot_row    = orow_reg;
    assign slot_column = ocol_reg;
    assign free_total  = ofree_reg;

`ifndef ASSERT_OFF
    // The free count never exceeds the number of slots.
    a_fcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= CNT_W'(TOTAL))
        else $error("free count above slot total");

    // Occupied slots and free count always add up to the grid size.
    a_map_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == (TOTAL - int'(fcount_reg)))
        else $error("occupancy map disagrees with free count");

    // A rejected word carries no slot.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((status_reg == ST_FULL) || (status_reg == ST_EMPTY)))
        |-> ((oser_reg == '0) && (orow_reg == '0) && (ocol_reg == '0)))
        else $error("rejected word carries a slot");

    // The remainder unit finishes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder done outside of the modulo step");
`endif

endmodule

FILE: tb/tb_random_free_slot_allocator.sv
// Self-checking testbench for the random free slot allocator.
module tb_random_free_slot_allocator;
    import rfsa_pkg::*;

    // One result word as the block presents it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OSER_W-1:0]   serial;
        logic [OROW_W-1:0]   row;
        logic [OCOL_W-1:0]   column;
        logic [OFREE_W-1:0]  free_now;
    } slot_result_t;

    // One row of the directed table; the result is typed in only when fixed is set.
    typedef struct packed {
        logic           op;
        logic [15:0]    pick_word;
        logic           fixed;
        slot_result_t   want;
    } slot_stim_t;

    localparam slot_result_t NO_CHECK = '0;
    localparam int DIRECTED_N = 19;
    localparam int PHASES = 6;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [CHOICE_W-1:0]   choice;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [OSER_W-1:0]     slot_serial;
    logic [OROW_W-1:0]     slot_row;
    logic [OCOL_W-1:0]     slot_column;
    logic [OFREE_W-1:0]    free_total;

    // Shadow copy of the allocator state.
    serial_t               shadow_free_list [TOTAL];
    logic [TOTAL-1:0]      shadow_taken;
    int unsigned           shadow_free_cnt;

    slot_result_t          pending_results [$];
    int unsigned           error_count;
    bit                    idle_on;

    // Directed words: empty rejects, extreme choice values, both operations, and a
    // drain back to an empty grid.
    slot_stim_t directed_rows [DIRECTED_N] = '{
        '{MODE_RELEASE, 16'h0000, 1'b1, '{ST_EMPTY, 5'd0, 3'd0, 3'd0, 5'd30}},
        '{MODE_RELEASE, 16'hFFFF, 1'b1, '{ST_EMPTY, 5'd0, 3'd0, 3'd0, 5'd30}},
        '{MODE_ALLOC,   16'h0000, 1'b1, '{ST_ALLOC, 5'd1, 3'd1, 3'd1, 5'd29}},
        '{MODE_ALLOC,   16'hFFFF, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'h8000, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'h0001, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'h7FFF, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h0000, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'hFFFF, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'h5555, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'hAAAA, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h0001, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h8000, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h7FFF, 1'b0, NO_CHECK},
        '{MODE_ALLOC,   16'h001D, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h0002, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h0000, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h0000, 1'b0, NO_CHECK},
        '{MODE_RELEASE, 16'h1234, 1'b1, '{ST_EMPTY, 5'd0, 3'd0, 3'd0, 5'd30}}
    };

    // Random phases: length and percentage of allocate words in each.
    int phase_len [PHASES] = '{40, 90, 45, 180, 160, 120};
    int alloc_pct [PHASES] = '{100, 85, 3, 50, 65, 50};

    random_free_slot_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .choice      (choice),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .slot_serial (slot_serial),
        .slot_row    (slot_row),
        .slot_column (slot_column),
        .free_total  (free_total)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Apply one word to the shadow state and return the result it must produce.
    function automatic slot_result_t predict_slot(input logic op, input logic [15:0] pick_word);
        slot_result_t r;
        int unsigned  pick;
        int unsigned  ser;
        int unsigned  seen;
        int unsigned  k;
        r = '0;
        ser = 0;
        seen = 0;
        if (op == MODE_ALLOC)
        begin
            if (shadow_free_cnt == 0)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // Take the picked list entry and close the gap behind it.
                pick = pick_word % shadow_free_cnt;
                ser = shadow_free_list[pick];
                shadow_taken[ser - 1] = 1'b1;
                for (k = pick + 1; k < shadow_free_cnt; k++)
                begin
                    shadow_free_list[k - 1] = shadow_free_list[k];
                end
                shadow_free_cnt--;
                r.status = ST_ALLOC;
            end
        end
        else
        begin
            if (shadow_free_cnt == TOTAL)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                // Find the picked occupied slot in row-major order.
                pick = pick_word % (TOTAL - shadow_free_cnt);
                for (k = 0; k < TOTAL; k++)
                begin
                    if (shadow_taken[k])
                    begin
                        if (seen == pick && ser == 0)
                        begin
                            ser = k + 1;
                        end
                        seen++;
                    end
                end
                shadow_taken[ser - 1] = 1'b0;
                shadow_free_list[shadow_free_cnt] = serial_t'(ser);
                shadow_free_cnt++;
                r.status = ST_REL;
            end
        end
        r.serial = ser[OSER_W-1:0];
        if (ser != 0)
        begin
            r.row = OROW_W'((ser - 1) / COLS + 1);
            r.column = OCOL_W'((ser - 1) % COLS + 1);
        end
        r.free_now = shadow_free_cnt[OFREE_W-1:0];
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Present one word, hold it until accepted, then queue its expected result.
    task automatic send_word(input logic op, input logic [15:0] pick_word,
                             input logic fixed, input slot_result_t want);
        slot_result_t predicted;
        in_valid <= 1'b1;
        mode <= op;
        choice <= pick_word;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predicted = predict_slot(op, pick_word);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Random sender gap after an accepted word, taken now and then while idles are on.
    task automatic sender_gap();
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every queued result has come back. With nothing
    // outstanding the sender is already idle, so valid is left alone.
    task automatic wait_drained();
        if (pending_results.size() != 0)
        begin
            in_valid <= 1'b0;
        end
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        int          p;
        int          n;
        logic        op;
        logic [15:0] pick_word;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_ALLOC;
        choice <= '0;
        idle_on = 1'b1;
        error_count = 0;
        for (n = 0; n < TOTAL; n++)
        begin
            shadow_free_list[n] = serial_t'(n + 1);
        end
        shadow_taken = '0;
        shadow_free_cnt = TOTAL;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (n = 0; n < DIRECTED_N; n++)
        begin
            send_word(directed_rows[n].op, directed_rows[n].pick_word,
                      directed_rows[n].fixed, directed_rows[n].want);
            sender_gap();
        end
        wait_drained();

        // Random phases, some biased toward filling or emptying the grid.
        for (p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            for (n = 0; n < phase_len[p]; n++)
            begin
                op = ($urandom_range(1, 100) <= alloc_pct[p]) ? MODE_ALLOC : MODE_RELEASE;
                case ($urandom_range(0, 9))
                    0: pick_word = 16'(TOTAL - 1 - $urandom_range(0, 2));
                    1: pick_word = 16'($urandom_range(0, 40));
                    2: pick_word = 16'hFFFF - 16'($urandom_range(0, 3));
                    default: pick_word = 16'($urandom_range(0, 65535));
                endcase
                send_word(op, pick_word, 1'b0, NO_CHECK);
                sender_gap();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: check each accepted word and drive out_ready with random stalls.
    initial
    begin
        int           stall_left;
        slot_result_t got;
        slot_result_t want;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{status, slot_serial, slot_row, slot_column, free_total};
                if (pending_results.size() == 0)
                begin
                    report_error($sformatf("unexpected result word st=%0d ser=%0d",
                                           got.status, got.serial));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.serial !== want.serial ||
                        got.row !== want.row || got.column !== want.column ||
                        got.free_now !== want.free_now)
                    begin
                        // Fields in order: status, serial, row, column, free count.
                        report_error($sformatf(
                            "mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                            want.status, want.serial, want.row, want.column, want.free_now,
                            got.status, got.serial, got.row, got.column, got.free_now));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
